// ===== design/dwc_pkg.sv =====
// Shared types and constants for the depthwise convolution core.
package dwc_pkg;

    // Request opcodes as they arrive on the input channel.
    typedef enum logic [1:0] {
        OP_TAP_WR  = 2'd0,
        OP_PIX_WR  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_UNUSED  = 2'd3
    } t_opcode;

    // Work class decided by the front end.
    typedef enum logic [1:0] {
        KIND_NOP  = 2'd0,
        KIND_TAP  = 2'd1,
        KIND_PIX  = 2'd2,
        KIND_COMP = 2'd3
    } t_kind;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PLANE_SIZE  = 2'd0;
    localparam logic [1:0] CFG_KERNEL_SIZE = 2'd1;

    localparam int DATA_W   = 16;
    localparam int COORD_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;
    localparam int PLANE_W  = 6;
    localparam int KSIZE_W  = 3;

    // Signed window coordinate: covers -3 .. 34 for kernels up to 7.
    localparam int IDX_W    = 8;
    // Products are Q.20 in 32 bits; up to 49 of them summed.
    localparam int PROD_W   = 2 * DATA_W;
    localparam int ACC_W    = 40;
    localparam int FRAC_SHIFT = 12;
    localparam int Q_W      = ACC_W - FRAC_SHIFT;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2048);
    localparam logic signed [Q_W-1:0]   Q_MAX      = Q_W'(32767);
    localparam logic signed [Q_W-1:0]   Q_MIN      = -Q_W'(32768);
    localparam logic signed [DATA_W-1:0] OUT_MAX   = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] OUT_MIN   = 16'sh8000;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        t_kind                     kind;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic signed [DATA_W-1:0]  data;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_qhead;

endpackage

// ===== design/dwc_if.sv =====
// Channel interfaces: input requests, results and configuration writes.
interface dwc_in_if import dwc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 opcode;
    logic [COORD_W-1:0]         row_index;
    logic [COORD_W-1:0]         col_index;
    logic signed [DATA_W-1:0]   data_value;

    modport source (output valid, output opcode, output row_index, output col_index,
                    output data_value, input ready);
    modport sink   (input valid, input opcode, input row_index, input col_index,
                    input data_value, output ready);
endinterface

interface dwc_out_if import dwc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   out_value;
    logic                       saturated;

    modport source (output valid, output out_value, output saturated, input ready);
    modport sink   (input valid, input out_value, input saturated, output ready);
endinterface

interface dwc_cfg_if import dwc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DAT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/dwc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module dwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/dwc_front.sv =====
// Front end: accepts requests, classifies them and holds them in a short queue.
module dwc_front import dwc_pkg::*; #(
    parameter int MAX_PLANE  = 32,
    parameter int MAX_KERNEL = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dwc_in_if.sink      i_in,
    input  logic        i_pop,
    output t_qhead      o_head
);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_req               r_q [QUEUE_DEPTH];
    logic               r_wptr, n_wptr;
    logic               r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               push;
    t_req               cls;

    assign i_in.ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign push       = i_in.valid && i_in.ready;

    // Classify: out-of-store writes and the unused opcode become no-ops.
    always_comb begin
        cls.row  = i_in.row_index;
        cls.col  = i_in.col_index;
        cls.data = i_in.data_value;
        case (t_opcode'(i_in.opcode))
            OP_TAP_WR: begin
                cls.kind = (32'(i_in.row_index) < MAX_KERNEL &&
                            32'(i_in.col_index) < MAX_KERNEL) ? KIND_TAP : KIND_NOP;
            end
            OP_PIX_WR: begin
                cls.kind = (32'(i_in.row_index) < MAX_PLANE &&
                            32'(i_in.col_index) < MAX_PLANE) ? KIND_PIX : KIND_NOP;
            end
            OP_COMPUTE: cls.kind = KIND_COMP;
            default:    cls.kind = KIND_NOP;
        endcase
    end

    always_comb begin
        n_wptr = push  ? ~r_wptr : r_wptr;
        n_rptr = i_pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + CNT_W'(push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cls;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.req   = r_q[r_rptr];
endmodule

// ===== design/dwc_back.sv =====
// Back end: store writes and the tap-serial multiply-accumulate for computes.
module dwc_back import dwc_pkg::*; #(
    parameter int MAX_PLANE  = 32,
    parameter int MAX_KERNEL = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_qhead               i_head,
    output logic                 o_pop,
    input  logic [PLANE_W-1:0]   i_plane_size,
    input  logic [KSIZE_W-1:0]   i_kernel_size,
    dwc_out_if.source            o_out
);
    localparam int PIX_DEPTH = MAX_PLANE * MAX_PLANE;
    localparam int TAP_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int PA_W = PIX_DEPTH > 1 ? $clog2(PIX_DEPTH) : 1;
    localparam int KA_W = TAP_DEPTH > 1 ? $clog2(TAP_DEPTH) : 1;
    localparam int KW   = $clog2(MAX_KERNEL + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [KW-1:0]              r_kr, n_kr, r_kc, n_kc, r_k, n_k;
    logic signed [IDX_W-1:0]    r_ir, n_ir, r_ic, n_ic, r_ic0, n_ic0, r_n, n_n;
    logic                       r_v1, n_v1, r_v2, n_v2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic                       r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0]   r_out_value, n_out_value;
    logic                       r_out_sat, n_out_sat;

    logic                       slot_free;
    logic                       tap_we, pix_we;
    logic [KW-1:0]              k_eff;
    logic signed [IDX_W-1:0]    n_eff, pad_s, row_s, col_s;
    logic                       inb;
    logic [PA_W-1:0]            pix_raddr, pix_waddr;
    logic [KA_W-1:0]            tap_raddr, tap_waddr;
    logic [DATA_W-1:0]          pix_rd, tap_rd;
    logic signed [ACC_W-1:0]    rnd;
    logic signed [Q_W-1:0]      q;

    assign slot_free = !r_out_valid || o_out.ready;

    // Clamp geometry to what the stores hold.
    assign k_eff = (32'(i_kernel_size) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(i_kernel_size);
    assign n_eff = (32'(i_plane_size) > MAX_PLANE) ? IDX_W'(MAX_PLANE)
                                                  : $signed(IDX_W'(i_plane_size));
    assign pad_s = $signed(IDX_W'(k_eff >> 1));
    assign row_s = $signed(IDX_W'(i_head.req.row));
    assign col_s = $signed(IDX_W'(i_head.req.col));

    assign inb = (r_ir >= 0) && (r_ir < r_n) && (r_ic >= 0) && (r_ic < r_n);

    assign pix_raddr = inb ? PA_W'($unsigned(PA_W'(r_ir) * PA_W'(MAX_PLANE) + PA_W'(r_ic)))
                           : '0;
    assign tap_raddr = KA_W'(KA_W'(r_kr) * KA_W'(MAX_KERNEL) + KA_W'(r_kc));
    assign pix_waddr = PA_W'(PA_W'(i_head.req.row) * PA_W'(MAX_PLANE) +
                             PA_W'(i_head.req.col));
    assign tap_waddr = KA_W'(KA_W'(i_head.req.row) * KA_W'(MAX_KERNEL) +
                             KA_W'(i_head.req.col));

    dwc_ram #(.WIDTH(DATA_W), .DEPTH(PIX_DEPTH)) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (i_head.req.data),
        .i_raddr (pix_raddr),
        .o_rdata (pix_rd)
    );

    dwc_ram #(.WIDTH(DATA_W), .DEPTH(TAP_DEPTH)) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (tap_waddr),
        .i_wdata (i_head.req.data),
        .i_raddr (tap_raddr),
        .o_rdata (tap_rd)
    );

    // Round half up by floor of (acc + 2^11) / 2^12, then saturate.
    assign rnd = r_acc + ROUND_BIAS;
    assign q   = $signed(rnd[ACC_W-1:FRAC_SHIFT]);

    always_comb begin
        n_state     = r_state;
        n_kr        = r_kr;
        n_kc        = r_kc;
        n_k         = r_k;
        n_ir        = r_ir;
        n_ic        = r_ic;
        n_ic0       = r_ic0;
        n_n         = r_n;
        n_v1        = 1'b0;
        n_v2        = r_v1;
        n_acc       = r_v2 ? r_acc + ACC_W'(r_prod) : r_acc;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_value = r_out_value;
        n_out_sat   = r_out_sat;
        o_pop       = 1'b0;
        tap_we      = 1'b0;
        pix_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.req.kind == KIND_COMP) begin
                        o_pop   = 1'b1;
                        n_kr    = '0;
                        n_kc    = '0;
                        n_k     = k_eff;
                        n_n     = n_eff;
                        n_ir    = row_s - pad_s;
                        n_ic    = col_s - pad_s;
                        n_ic0   = col_s - pad_s;
                        n_acc   = '0;
                        n_state = (k_eff == '0) ? S_DRAIN : S_RUN;
                    end else if (slot_free) begin
                        o_pop       = 1'b1;
                        tap_we      = (i_head.req.kind == KIND_TAP);
                        pix_we      = (i_head.req.kind == KIND_PIX);
                        n_out_valid = 1'b1;
                        n_out_value = '0;
                        n_out_sat   = 1'b0;
                    end
                end
            end
            S_RUN: begin
                n_v1 = inb;
                if (r_kc == r_k - KW'(1)) begin
                    n_kc = '0;
                    n_ic = r_ic0;
                    n_kr = r_kr + KW'(1);
                    n_ir = r_ir + IDX_W'(1);
                    if (r_kr == r_k - KW'(1)) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_kc = r_kc + KW'(1);
                    n_ic = r_ic + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (q > Q_MAX) begin
                        n_out_value = OUT_MAX;
                        n_out_sat   = 1'b1;
                    end else if (q < Q_MIN) begin
                        n_out_value = OUT_MIN;
                        n_out_sat   = 1'b1;
                    end else begin
                        n_out_value = q[DATA_W-1:0];
                        n_out_sat   = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kr        <= n_kr;
        r_kc        <= n_kc;
        r_k         <= n_k;
        r_ir        <= n_ir;
        r_ic        <= n_ic;
        r_ic0       <= n_ic0;
        r_n         <= n_n;
        r_prod      <= $signed(pix_rd) * $signed(tap_rd);
        r_acc       <= n_acc;
        r_out_value <= n_out_value;
        r_out_sat   <= n_out_sat;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_value = r_out_value;
    assign o_out.saturated = r_out_sat;
endmodule

// ===== design/depthwise_convolution_2d_core.sv =====
// Top level: depthwise 2-D convolution, same padding, one channel plane at a time.
// Path: a write or no-op yields its zero result through the queue and the result register;
// a compute passes the queue, steps its taps in S_RUN through the RAM read and product
// registers, empties them in S_DRAIN, rounds in S_DONE and lands in the result register.
// Throughput: one write per cycle while results are taken; a compute holds the back end
// until its result is offered, one tap per cycle through the single multiply-accumulate.
// Reset (i_rst_n, synchronous, low): sizes 19 and 3, queue and result empty, stores kept.
module depthwise_convolution_2d_core import dwc_pkg::*; #(
    parameter int MAX_PLANE  = 32,
    parameter int MAX_KERNEL = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dwc_in_if.sink      i_in,
    dwc_out_if.source   o_out,
    dwc_cfg_if.sink     i_cfg
);
    // Configuration registers: the user writes them only while the core is idle; not enforced here.
    logic [PLANE_W-1:0] r_plane_size, n_plane_size;
    logic [KSIZE_W-1:0] r_kernel_size, n_kernel_size;

    // Request queue head and pop between the two halves.
    t_qhead head;
    logic   pop;

    // The configuration port never stalls.
    assign i_cfg.ready = 1'b1;

    // Decode the register index; writes beyond the list are dropped.
    always_comb begin
        n_plane_size  = r_plane_size;
        n_kernel_size = r_kernel_size;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PLANE_SIZE:  n_plane_size  = i_cfg.data[PLANE_W-1:0];
                CFG_KERNEL_SIZE: n_kernel_size = i_cfg.data[KSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_size  <= PLANE_W'(19);
            r_kernel_size <= KSIZE_W'(3);
        end else begin
            r_plane_size  <= n_plane_size;
            r_kernel_size <= n_kernel_size;
        end
    end

    // Front: accept, classify (drop out-of-store writes to no-ops), queue.
    dwc_front #(.MAX_PLANE(MAX_PLANE), .MAX_KERNEL(MAX_KERNEL)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (pop),
        .o_head  (head)
    );

    // Back: perform stores, step taps through the MAC, round, saturate, hold result.
    dwc_back #(.MAX_PLANE(MAX_PLANE), .MAX_KERNEL(MAX_KERNEL)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_plane_size  (r_plane_size),
        .i_kernel_size (r_kernel_size),
        .o_out         (o_out)
    );
endmodule

// ===== design/dwc_checker.sv =====
// Port-level assertions for the depthwise convolution core, bound to the top level.
module dwc_checker import dwc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [DATA_W-1:0]  i_out_value,
    input  logic                      i_out_sat
);
    // A result held back by the sink stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_value) && $stable(i_out_sat))
        else $error("result payload changed while stalled");

    // A clipped result sits exactly at a range limit.
    a_sat_limit: assert property (@(posedge i_clk)
        i_out_valid && i_out_sat |-> (i_out_value == OUT_MAX || i_out_value == OUT_MIN))
        else $error("saturated result not at a limit");

    // Nothing is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");
endmodule

bind depthwise_convolution_2d_core dwc_checker u_dwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.out_value),
    .i_out_sat   (o_out.saturated)
);
